// ===== rtl/asdz_pkg.sv =====
// Shared constants for the analog stick dead zone scaler.
package asdz_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned FRAC_W     = 15;
  localparam int unsigned REG_W      = 16;
  localparam int unsigned TDZ_W      = 15;

  localparam logic [CFG_IDX_W-1:0] REG_TRIG_DZ = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_FS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_DZ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_FS = 3'd3;

  localparam logic [TDZ_W-1:0]  RST_TRIG_DZ  = 15'd250;
  localparam logic [REG_W-1:0]  RST_TRIG_FS  = 16'd32767;
  localparam logic [REG_W-1:0]  RST_STICK_DZ = 16'd8000;
  localparam logic [REG_W-1:0]  RST_STICK_FS = 16'd30000;

  localparam logic [FRAC_W-1:0] FULL_OUT = 15'd32767;

endpackage

// ===== rtl/asdz_in_if.sv =====
// Input word channel: reading kind and raw axis values.
interface asdz_in_if #(
  parameter int unsigned AXIS_BITS = 17
);
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic signed [AXIS_BITS-1:0] axis_x;
  logic signed [AXIS_BITS-1:0] axis_y;

  modport source (output valid, kind, axis_x, axis_y, input ready);
  modport sink   (input valid, kind, axis_x, axis_y, output ready);
endinterface

// ===== rtl/asdz_out_if.sv =====
// Output word channel: scaled Q1.15 axis values.
interface asdz_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;

  modport source (output valid, out_x, out_y, input ready);
  modport sink   (input valid, out_x, out_y, output ready);
endinterface

// ===== rtl/analog_stick_deadzone_scaler_unit.sv =====
// Pipelined dead zone removal and Q1.15 rescale for trigger and stick readings.
//
// Usage:
//   in_i carries one reading per word: kind (0 trigger, 1 stick), axis_x, axis_y.
//   out_o carries one result word per reading: out_x, out_y in Q1.15.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the four dead zone and full scale registers;
//   write them only while no word is in flight.
// Stages: three input and squaring stages (capture, square, sum), one stage per
//   root bit of the square root, three scaling stages, sixteen restoring divider
//   stages and the output register.
// Throughput: one word per cycle unless stalled; each stage has its own valid bit.
// Stall: each stage holds while the one after it is full and stalled; empty
//   stages still fill, so in_i.ready stays high until the pipeline is full.
// Reset: rst_ni clears all valid bits and loads the register defaults
//   (trigger 250/32767, stick 8000/30000); no word is lost or repeated on a stall.
module analog_stick_deadzone_scaler_unit import asdz_pkg::*; #(
  parameter int unsigned AXIS_BITS = 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  asdz_in_if.sink               in_i,
  asdz_out_if.source            out_o
);

  localparam int unsigned A    = AXIS_BITS;
  localparam int unsigned SQW  = 2 * A;
  localparam int unsigned CW   = ((A > REG_W) ? A : REG_W) + 1;
  localparam int unsigned PW   = A + REG_W;
  localparam int unsigned NW   = PW + FRAC_W;
  localparam int unsigned DV_N = FRAC_W + 1;

  localparam int unsigned S_IN  = 0;
  localparam int unsigned S_SQ  = 1;
  localparam int unsigned S_SUM = 2;
  localparam int unsigned S_RT  = 3;
  localparam int unsigned S_E1  = S_RT + A;
  localparam int unsigned S_E2  = S_E1 + 1;
  localparam int unsigned S_E3  = S_E2 + 1;
  localparam int unsigned S_DV  = S_E3 + 1;
  localparam int unsigned S_OUT = S_DV + DV_N;
  localparam int unsigned NS    = S_OUT + 1;

  typedef struct packed {
    logic         kind;
    logic         sx;
    logic         sy;
    logic [A-1:0] ax;
    logic [A-1:0] ay;
  } side_t;

  typedef struct packed {
    logic kind;
    logic sx;
    logic sy;
    logic zero;
    logic full;
  } flag_t;

  logic [TDZ_W-1:0] trig_dz_q;
  logic [REG_W-1:0] trig_fs_q;
  logic [REG_W-1:0] stick_dz_q;
  logic [REG_W-1:0] stick_fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_dz_q  <= RST_TRIG_DZ;
      trig_fs_q  <= RST_TRIG_FS;
      stick_dz_q <= RST_STICK_DZ;
      stick_fs_q <= RST_STICK_FS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TRIG_DZ:  trig_dz_q  <= cfg_data_i[TDZ_W-1:0];
        REG_TRIG_FS:  trig_fs_q  <= cfg_data_i[REG_W-1:0];
        REG_STICK_DZ: stick_dz_q <= cfg_data_i[REG_W-1:0];
        REG_STICK_FS: stick_fs_q <= cfg_data_i[REG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  assign en[NS] = out_o.ready;
  for (genvar s = 0; s < NS; s++) begin : g_en
    assign en[s] = !v_q[s] || en[s+1];
  end
  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // input capture: signs and magnitudes
  side_t in_side_q;
  always_ff @(posedge clk_i) begin
    if (en[S_IN]) begin
      in_side_q.kind <= in_i.kind;
      in_side_q.sx   <= in_i.axis_x[A-1];
      in_side_q.sy   <= in_i.axis_y[A-1];
      in_side_q.ax   <= in_i.axis_x[A-1] ? (~in_i.axis_x + A'(1)) : in_i.axis_x;
      in_side_q.ay   <= in_i.axis_y[A-1] ? (~in_i.axis_y + A'(1)) : in_i.axis_y;
    end
  end

  side_t          sq_side_q;
  logic [SQW-1:0] sqx_q, sqy_q;
  always_ff @(posedge clk_i) begin
    if (en[S_SQ]) begin
      sq_side_q <= in_side_q;
      sqx_q     <= SQW'(in_side_q.ax) * SQW'(in_side_q.ax);
      sqy_q     <= SQW'(in_side_q.ay) * SQW'(in_side_q.ay);
    end
  end

  side_t          sum_side_q;
  logic [SQW-1:0] sum_q;
  always_ff @(posedge clk_i) begin
    if (en[S_SUM]) begin
      sum_side_q <= sq_side_q;
      sum_q      <= sqx_q + sqy_q;
    end
  end

  // square root: one result bit per stage
  side_t          rt_side_q [A];
  logic [SQW-1:0] rt_rem_q  [A];
  logic [A-1:0]   rt_root_q [A];

  for (genvar g = 0; g < A; g++) begin : g_rt
    localparam int unsigned K = A - 1 - g;
    side_t          side_in;
    logic [SQW-1:0] rem_in;
    logic [A-1:0]   root_in;
    logic [SQW:0]   trial;
    if (g == 0) begin : g_first
      assign side_in = sum_side_q;
      assign rem_in  = sum_q;
      assign root_in = '0;
    end else begin : g_next
      assign side_in = rt_side_q[g-1];
      assign rem_in  = rt_rem_q[g-1];
      assign root_in = rt_root_q[g-1];
    end
    assign trial = ((SQW+1)'(root_in) << (K + 1)) + ((SQW+1)'(1) << (2 * K));
    always_ff @(posedge clk_i) begin
      if (en[S_RT+g]) begin
        rt_side_q[g] <= side_in;
        if ({1'b0, rem_in} >= trial) begin
          rt_rem_q[g]  <= rem_in - trial[SQW-1:0];
          rt_root_q[g] <= root_in | (A'(1) << K);
        end else begin
          rt_rem_q[g]  <= rem_in;
          rt_root_q[g] <= root_in;
        end
      end
    end
  end

  // scale setup: multiplicands and forced outcomes
  side_t        rs;
  logic [A-1:0] len;
  logic [CW-1:0] a_c, tdz_c, tfs_c, sdz_c, sfs_c, len_c, fsd_c, ld_c;
  flag_t        e1_flag_d, e1_flag_q;
  logic [A-1:0] e1_mx_d, e1_my_d, e1_mdb_d, e1_mx_q, e1_my_q, e1_mdb_q;
  logic [REG_W-1:0] e1_mn_d, e1_mda_d, e1_mn_q, e1_mda_q;

  assign rs    = rt_side_q[A-1];
  assign len   = rt_root_q[A-1];
  assign a_c   = CW'(rs.ax);
  assign tdz_c = CW'(trig_dz_q);
  assign tfs_c = CW'(trig_fs_q);
  assign sdz_c = CW'(stick_dz_q);
  assign sfs_c = CW'(stick_fs_q);
  assign len_c = CW'(len);
  assign fsd_c = sfs_c - sdz_c;
  assign ld_c  = len_c - sdz_c;

  always_comb begin
    e1_flag_d.kind = rs.kind;
    e1_flag_d.sx   = rs.sx;
    e1_flag_d.sy   = rs.sy;
    e1_flag_d.zero = 1'b0;
    e1_flag_d.full = 1'b0;
    e1_mx_d  = rs.ax;
    e1_my_d  = '0;
    e1_mn_d  = REG_W'(1);
    e1_mda_d = REG_W'(1);
    e1_mdb_d = A'(1);
    if (!rs.kind) begin
      e1_flag_d.zero = (a_c <= tdz_c);
      e1_flag_d.full = (tfs_c <= tdz_c);
      e1_mx_d        = A'(a_c - tdz_c);
      e1_mda_d       = REG_W'(tfs_c - tdz_c);
    end else begin
      e1_flag_d.zero = (len_c < sdz_c) || (len == '0);
      e1_my_d        = rs.ay;
      e1_mdb_d       = len;
      if (sfs_c > sdz_c) begin
        e1_mn_d  = (ld_c > fsd_c) ? REG_W'(fsd_c) : REG_W'(ld_c);
        e1_mda_d = REG_W'(fsd_c);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_E1]) begin
      e1_flag_q <= e1_flag_d;
      e1_mx_q   <= e1_mx_d;
      e1_my_q   <= e1_my_d;
      e1_mn_q   <= e1_mn_d;
      e1_mda_q  <= e1_mda_d;
      e1_mdb_q  <= e1_mdb_d;
    end
  end

  flag_t         e2_flag_q;
  logic [PW-1:0] e2_px_q, e2_py_q, e2_d_q;
  always_ff @(posedge clk_i) begin
    if (en[S_E2]) begin
      e2_flag_q <= e1_flag_q;
      e2_px_q   <= PW'(e1_mx_q) * PW'(e1_mn_q);
      e2_py_q   <= PW'(e1_my_q) * PW'(e1_mn_q);
      e2_d_q    <= PW'(e1_mda_q) * PW'(e1_mdb_q);
    end
  end

  flag_t         e3_flag_q;
  logic [NW-1:0] e3_nx_q, e3_ny_q;
  logic [PW-1:0] e3_d_q;
  always_ff @(posedge clk_i) begin
    if (en[S_E3]) begin
      e3_flag_q <= e2_flag_q;
      e3_nx_q   <= (NW'(e2_px_q) << FRAC_W) - NW'(e2_px_q);
      e3_ny_q   <= (NW'(e2_py_q) << FRAC_W) - NW'(e2_py_q);
      e3_d_q    <= e2_d_q;
    end
  end

  // restoring divider: overflow check, then one quotient bit per stage
  flag_t           dv_flag_q [DV_N];
  logic [NW-1:0]   dv_rx_q   [DV_N];
  logic [NW-1:0]   dv_ry_q   [DV_N];
  logic [PW-1:0]   dv_d_q    [DV_N];
  logic [FRAC_W-1:0] dv_qx_q [DV_N];
  logic [FRAC_W-1:0] dv_qy_q [DV_N];
  logic            dv_satx_q [DV_N];
  logic            dv_saty_q [DV_N];

  for (genvar g = 0; g < DV_N; g++) begin : g_dv
    localparam int unsigned I = FRAC_W - g;
    flag_t             flag_in;
    logic [NW-1:0]     rx_in, ry_in, dsh, rx_nx, ry_nx;
    logic [PW-1:0]     d_in;
    logic [FRAC_W-1:0] qx_nx, qy_nx;
    logic              ge_x, ge_y, satx_nx, saty_nx;
    if (g == 0) begin : g_first
      assign flag_in = e3_flag_q;
      assign rx_in   = e3_nx_q;
      assign ry_in   = e3_ny_q;
      assign d_in    = e3_d_q;
      assign rx_nx   = rx_in;
      assign ry_nx   = ry_in;
      assign qx_nx   = '0;
      assign qy_nx   = '0;
      assign satx_nx = ge_x;
      assign saty_nx = ge_y;
    end else begin : g_next
      assign flag_in = dv_flag_q[g-1];
      assign rx_in   = dv_rx_q[g-1];
      assign ry_in   = dv_ry_q[g-1];
      assign d_in    = dv_d_q[g-1];
      assign rx_nx   = ge_x ? (rx_in - dsh) : rx_in;
      assign ry_nx   = ge_y ? (ry_in - dsh) : ry_in;
      assign qx_nx   = ge_x ? (dv_qx_q[g-1] | (FRAC_W'(1) << I)) : dv_qx_q[g-1];
      assign qy_nx   = ge_y ? (dv_qy_q[g-1] | (FRAC_W'(1) << I)) : dv_qy_q[g-1];
      assign satx_nx = dv_satx_q[g-1];
      assign saty_nx = dv_saty_q[g-1];
    end
    assign dsh  = NW'(d_in) << I;
    assign ge_x = (rx_in >= dsh);
    assign ge_y = (ry_in >= dsh);
    always_ff @(posedge clk_i) begin
      if (en[S_DV+g]) begin
        dv_flag_q[g] <= flag_in;
        dv_d_q[g]    <= d_in;
        dv_rx_q[g]   <= rx_nx;
        dv_ry_q[g]   <= ry_nx;
        dv_qx_q[g]   <= qx_nx;
        dv_qy_q[g]   <= qy_nx;
        dv_satx_q[g] <= satx_nx;
        dv_saty_q[g] <= saty_nx;
      end
    end
  end

  // saturate, force and restore sign
  flag_t             fl;
  logic [FRAC_W-1:0] mag_x, mag_y;
  logic [OUT_W-1:0]  out_x_q, out_y_q;

  assign fl = dv_flag_q[DV_N-1];

  always_comb begin
    if (fl.zero) begin
      mag_x = '0;
    end else if (fl.full || dv_satx_q[DV_N-1]) begin
      mag_x = FULL_OUT;
    end else begin
      mag_x = dv_qx_q[DV_N-1];
    end
    if (fl.zero || !fl.kind) begin
      mag_y = '0;
    end else if (dv_saty_q[DV_N-1]) begin
      mag_y = FULL_OUT;
    end else begin
      mag_y = dv_qy_q[DV_N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_OUT]) begin
      out_x_q <= fl.sx ? (OUT_W'(0) - OUT_W'(mag_x)) : OUT_W'(mag_x);
      out_y_q <= fl.sy ? (OUT_W'(0) - OUT_W'(mag_y)) : OUT_W'(mag_y);
    end
  end

  assign out_o.valid = v_q[S_OUT];
  assign out_o.out_x = out_x_q;
  assign out_o.out_y = out_y_q;

endmodule
